### hdl/drs_pkg.sv
// shared types and constants of the disk request scheduler
package drs_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned TrackBits  = 16;
  localparam int unsigned TagBits    = 16;
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);
  localparam int unsigned PendBits   = 8;

  // byte address of the policy register
  localparam logic [1:0] RegPolicyMode = 2'd0;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdIssue  = 2'd1,
    CmdFinish = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StBusy  = 2'd2,
    StFull  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ModeFifo  = 3'd0,
    ModeSstf  = 3'd1,
    ModeScan  = 3'd2,
    ModeCscan = 3'd3,
    ModeFscan = 3'd4
  } mode_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [TrackBits-1:0] request_track;
    logic [TagBits-1:0]   request_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [TagBits-1:0]   chosen_tag;
    logic [TrackBits-1:0] chosen_track;
    logic [15:0]          seek_distance;
    logic [15:0]          head_position;
    logic [PendBits-1:0]  pending_count;
  } rsp_t;

  typedef struct packed {
    logic [TagBits-1:0]   tag;
    logic [TrackBits-1:0] track;
  } entry_t;

  // control from sequencer to the cell row
  typedef struct packed {
    logic                 append;    // write new entry into active row at the fill point
    logic                 append_w;  // same for the waiting row
    logic                 remove;    // compact active row over the given slot
    logic                 swap;      // exchange rows
    logic [CntBits-1:0]   slot;
    logic [CntBits-1:0]   act_n;
    logic [CntBits-1:0]   wait_n;
    entry_t               din;
  } row_ctl_t;

  // scan state travelling along the row
  typedef struct packed {
    logic                 found;
    logic [CntBits-1:0]   idx;
    logic [TrackBits-1:0] key;
  } best_t;

  // rank key: smaller wins, strictly, so earlier entries keep ties
  function automatic logic [TrackBits:0] rank_key(
    input logic [2:0] mode, input logic up, input logic wrap_pass,
    input logic [TrackBits-1:0] t, input logic [TrackBits-1:0] head);
    logic [TrackBits:0] k;
    k = '1;
    unique case (mode)
      ModeSstf:  k = {1'b0, (t >= head) ? t - head : head - t};
      ModeScan, ModeFscan: begin
        if (up) k = (t >= head) ? {1'b0, t} : '1;
        else k = (t <= head) ? {1'b0, ~t} : '1;
      end
      ModeCscan: begin
        if (wrap_pass) k = {1'b0, t};
        else k = (t >= head) ? {1'b0, t} : '1;
      end
      default:   k = '1;
    endcase
    return k;
  endfunction

endpackage

### hdl/disk_request_scheduler.sv
// top level of the disk request scheduler
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid_i/stall_o | drs_pkg::req_t
//  rsp     | out       | rsp_valid_o/stall_i | drs_pkg::rsp_t
//  cfg     | in        | apb                 | policy_mode at 0
//
// add, finish and error answers pass through the done state into the response register
// issue answers pass through the scan, wrap and done states; the scan tap walks the
//   cell row one slot per cycle (only slot 0 in fifo), and walks it a second time when
//   the sweep reverses or circular scan wraps
// a response register holds the result; the next transaction is taken the cycle
//   after the response is taken, so a stalled response stalls the input
// reset clears counts, valid state, head and mode; entry contents are left as is
module disk_request_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  drs_pkg::req_t        req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_stall_i,
  output drs_pkg::rsp_t        rsp_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import drs_pkg::*;

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SScan = 4'b0010,
    SWrap = 4'b0100,
    SDone = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] mode_q;
  logic [CntBits-1:0] act_n_q, act_n_d, wait_n_q, wait_n_d, tap_q, tap_d;
  logic [TrackBits-1:0] head_q, head_d;
  logic up_q, up_d, busy_q, busy_d;
  logic [CntBits-1:0] slot_q, slot_d;
  entry_t svc_q, svc_d;
  best_t best_q, best_d;
  logic rev_q, rev_d;   // scan retrying after a failed pass: reversed direction, or wrapped in circular scan
  logic pick_q, pick_d; // tap sits on the chosen slot, load it into service
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;
  row_ctl_t ctl;
  entry_t tap_w;
  logic accept;
  logic fscan;

  // config port, always ready
  assign pready = 1'b1;
  assign prdata = {29'd0, mode_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeFifo;
    end else if (psel && penable && pwrite && paddr == RegPolicyMode) begin
      mode_q <= pwdata[2:0];
    end
  end

  assign fscan = (mode_q == ModeFscan);
  assign req_stall_o = (state_q != SIdle) || rsp_valid_q;
  assign accept = req_valid_i && !req_stall_o;

  drs_row u_row (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .tap_i  (tap_q),
    .tap_o  (tap_w)
  );

  function automatic logic [15:0] dist16(input logic [TrackBits-1:0] a,
                                         input logic [TrackBits-1:0] b);
    return 16'((a >= b) ? a - b : b - a);
  endfunction

  logic [TrackBits:0] k_w;
  logic [PendBits-1:0] pend_w;

  always_comb begin
    state_d = state_q;
    act_n_d = act_n_q; wait_n_d = wait_n_q; tap_d = tap_q;
    head_d = head_q; up_d = up_q; busy_d = busy_q;
    slot_d = slot_q; svc_d = svc_q; best_d = best_q; rev_d = rev_q;
    pick_d = 1'b0;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    rsp_d = rsp_q;
    ctl = '0;
    ctl.act_n = act_n_q; ctl.wait_n = wait_n_q; ctl.slot = slot_q;
    ctl.din = '{tag: req_i.request_tag, track: req_i.request_track};
    // after a reversal up_q already points the new way
    k_w = rank_key(mode_q, up_q, rev_q, tap_w.track, head_q);
    pend_w = PendBits'(act_n_q) + PendBits'(wait_n_q);

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          rsp_d = '0;
          rsp_d.head_position = 16'(head_q);
          case (req_i.command)
            CmdAdd: begin
              if (fscan) begin
                if (wait_n_q == CntBits'(QueueDepth)) rsp_d.status = StFull;
                else begin ctl.append_w = 1'b1; wait_n_d = wait_n_q + 1'b1; end
              end else begin
                if (act_n_q == CntBits'(QueueDepth)) rsp_d.status = StFull;
                else begin ctl.append = 1'b1; act_n_d = act_n_q + 1'b1; end
              end
              state_d = SDone;
            end
            CmdIssue: begin
              if (busy_q) begin
                rsp_d.status = StBusy; state_d = SDone;
              end else if (act_n_q == '0 && wait_n_q == '0) begin
                rsp_d.status = StEmpty; state_d = SDone;
              end else begin
                if (act_n_q == '0) begin
                  ctl.swap = 1'b1; act_n_d = wait_n_q; wait_n_d = act_n_q; up_d = 1'b1;
                end
                tap_d = '0; best_d = '0; rev_d = 1'b0;
                state_d = SScan;
              end
            end
            CmdFinish: begin
              if (!busy_q) rsp_d.status = StBusy;
              else begin
                if (fscan && act_n_q == CntBits'(1)) begin
                  // fscan: the active row drains, the waiting row takes over
                  ctl.swap = 1'b1;
                  act_n_d = wait_n_q;
                  wait_n_d = '0;
                  up_d = 1'b1;
                end else begin
                  ctl.remove = 1'b1;
                  act_n_d = act_n_q - 1'b1;
                end
                rsp_d.chosen_tag = svc_q.tag;
                rsp_d.chosen_track = svc_q.track;
                head_d = svc_q.track;
                rsp_d.head_position = 16'(svc_q.track);
                busy_d = 1'b0;
              end
              state_d = SDone;
            end
            default: begin
              rsp_d.status = StBusy; state_d = SDone;
            end
          endcase
        end
      end
      SScan: begin
        // one slot per cycle, strict compare keeps the earliest on ties
        if (mode_q == ModeFifo || mode_q > ModeFscan) begin
          best_d = '{found: 1'b1, idx: '0, key: '0};
        end else if (!k_w[TrackBits] && (!best_q.found || k_w[TrackBits-1:0] < best_q.key)) begin
          best_d = '{found: 1'b1, idx: tap_q, key: k_w[TrackBits-1:0]};
        end
        tap_d = tap_q + 1'b1;
        if (tap_q + 1'b1 == act_n_q || mode_q == ModeFifo || mode_q > ModeFscan)
          state_d = SWrap;
      end
      SWrap: begin
        if (!best_q.found && !rev_q &&
            (mode_q == ModeScan || mode_q == ModeFscan || mode_q == ModeCscan)) begin
          rev_d = 1'b1; tap_d = '0; state_d = SScan;
          if (mode_q != ModeCscan) up_d = !up_q;
        end else begin
          // tap settles on the chosen slot before the done state loads it into service
          slot_d = best_q.found ? best_q.idx : '0;
          tap_d = slot_d;
          state_d = SDone;
          busy_d = 1'b1;
          pick_d = 1'b1;
        end
      end
      SDone: begin
        if (pick_q) begin
          svc_d = tap_w;
          rsp_d.chosen_tag = tap_w.tag;
          rsp_d.chosen_track = tap_w.track;
          rsp_d.seek_distance = dist16(tap_w.track, head_q);
        end
        rsp_d.pending_count = pend_w;
        rsp_valid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; act_n_q <= '0; wait_n_q <= '0; tap_q <= '0;
      head_q <= '0; up_q <= 1'b1; busy_q <= 1'b0; rsp_valid_q <= 1'b0;
      rev_q <= 1'b0; best_q <= '0; slot_q <= '0; pick_q <= 1'b0;
    end else begin
      state_q <= state_d; tap_q <= tap_d; head_q <= head_d;
      busy_q <= busy_d; rsp_valid_q <= rsp_valid_d; rev_q <= rev_d;
      best_q <= best_d; slot_q <= slot_d; pick_q <= pick_d;
      act_n_q <= act_n_d; wait_n_q <= wait_n_d; up_q <= up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    svc_q <= svc_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_stall_i |=> rsp_valid_q) else $error("response lost");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_n_q <= CntBits'(QueueDepth) && wait_n_q <= CntBits'(QueueDepth))
    else $error("queue count out of range");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> req_stall_o) else $error("accept during work");
endmodule

### hdl/drs_cell.sv
// one queue cell: holds an active and a waiting entry, shifts toward lower slots
module drs_cell (
  input  logic            clk_i,
  input  drs_pkg::row_ctl_t ctl_i,
  input  logic [drs_pkg::CntBits-1:0] pos_i,
  input  drs_pkg::entry_t next_i,
  output drs_pkg::entry_t act_o
);
  import drs_pkg::*;

  entry_t act_q, act_d, wait_q, wait_d;

  always_comb begin
    act_d  = act_q;
    wait_d = wait_q;
    if (ctl_i.swap) begin
      act_d  = wait_q;
      wait_d = act_q;
    end else begin
      if (ctl_i.append && pos_i == ctl_i.act_n) act_d = ctl_i.din;
      if (ctl_i.append_w && pos_i == ctl_i.wait_n) wait_d = ctl_i.din;
      if (ctl_i.remove && pos_i >= ctl_i.slot && pos_i < ctl_i.act_n) act_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    wait_q <= wait_d;
  end

  assign act_o  = act_q;
endmodule

### hdl/drs_row.sv
// row of queue cells with a scan tap that walks one slot per cycle
module drs_row (
  input  logic            clk_i,
  input  drs_pkg::row_ctl_t ctl_i,
  input  logic [drs_pkg::CntBits-1:0] tap_i,
  output drs_pkg::entry_t tap_o
);
  import drs_pkg::*;

  entry_t act_w [QueueDepth];

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    entry_t nxt;
    if (g + 1 < QueueDepth) begin : g_mid
      assign nxt = act_w[g+1];
    end else begin : g_end
      assign nxt = act_w[g];
    end
    drs_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .pos_i  (CntBits'(g)),
      .next_i (nxt),
      .act_o  (act_w[g])
    );
  end

  localparam int unsigned IdxBits = $clog2(QueueDepth);
  assign tap_o = act_w[tap_i[IdxBits-1:0]];
endmodule
